// File: rtl/tcwsq_pkg.sv
// Shared types and constants of the three-class windowed send queue
`timescale 1ns / 1ps
package tcwsq_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int PRI_W      = 3;
  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 11;
  localparam int FREE_W     = 10;
  localparam int WIN_W      = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 3;
  localparam int ENTRY_W    = ID_W + TIME_W;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_SEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SWEEP = 3'd3;
  localparam logic [OP_W-1:0] OP_WIN   = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd5;

  // Priority requests
  localparam logic [PRI_W-1:0] PRI_VHIGH  = 3'd0;
  localparam logic [PRI_W-1:0] PRI_HIGH   = 3'd1;
  localparam logic [PRI_W-1:0] PRI_NORMAL = 3'd2;
  localparam logic [PRI_W-1:0] PRI_LOW    = 3'd3;

  // Ring indexes
  localparam logic [1:0] RING_HIGH   = 2'd0;
  localparam logic [1:0] RING_NORMAL = 2'd1;
  localparam logic [1:0] RING_LOW    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPRI = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WIN    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEND_SPEED = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT    = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEND_WAIT,
    S_SEND_CAP,
    S_ACK_CHK,
    S_ACK_CMP,
    S_SWP_CHK,
    S_SWP_CMP,
    S_WIN_TOT,
    S_WIN_RING,
    S_CNT_FIN,
    S_DONE
  } ctrl_state_t;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ENQ,
    CMD_QUERY,
    CMD_SEND_SEL,
    CMD_SEND_CAP,
    CMD_SCAN_START,
    CMD_NEXT_RING,
    CMD_ACK_CMP,
    CMD_SWP_CMP,
    CMD_WIN_TOT,
    CMD_WIN_RING,
    CMD_CNT_FIN,
    CMD_PUSH
  } dp_cmd_t;

  // Datapath status towards the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            at_send;
    logic            last_ring;
    logic            send_found;
    logic            id_match;
    logic            aged;
    logic            res_free;
  } dp_sts_t;

endpackage

// File: rtl/tcwsq_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tcwsq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/tcwsq_ctrl.sv
// Sequencing state machine of the send queue
`timescale 1ns / 1ps
module tcwsq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tcwsq_pkg::dp_sts_t sts,
  output tcwsq_pkg::dp_cmd_t cmd
);
  import tcwsq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ENQ: begin
            cmd       = CMD_ENQ;
            state_nxt = S_DONE;
          end
          OP_QUERY: begin
            cmd       = CMD_QUERY;
            state_nxt = S_DONE;
          end
          OP_SEND: begin
            cmd       = CMD_SEND_SEL;
            state_nxt = sts.send_found ? S_SEND_WAIT : S_DONE;
          end
          OP_ACK: begin
            cmd       = CMD_SCAN_START;
            state_nxt = S_ACK_CHK;
          end
          OP_SWEEP: begin
            cmd       = CMD_SCAN_START;
            state_nxt = S_SWP_CHK;
          end
          OP_WIN: begin
            state_nxt = S_WIN_TOT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SEND_WAIT: begin
        state_nxt = S_SEND_CAP;
      end
      S_SEND_CAP: begin
        cmd       = CMD_SEND_CAP;
        state_nxt = S_DONE;
      end
      // Walk the unacknowledged entries ring by ring
      S_ACK_CHK: begin
        if (sts.at_send) begin
          if (sts.last_ring) begin
            state_nxt = S_DONE;
          end else begin
            cmd = CMD_NEXT_RING;
          end
        end else begin
          state_nxt = S_ACK_CMP;
        end
      end
      S_ACK_CMP: begin
        cmd       = CMD_ACK_CMP;
        state_nxt = sts.id_match ? S_DONE : S_ACK_CHK;
      end
      // Retire aged heads ring by ring
      S_SWP_CHK: begin
        if (sts.at_send) begin
          if (sts.last_ring) begin
            state_nxt = S_CNT_FIN;
          end else begin
            cmd = CMD_NEXT_RING;
          end
        end else begin
          state_nxt = S_SWP_CMP;
        end
      end
      S_SWP_CMP: begin
        cmd = CMD_SWP_CMP;
        if (sts.aged) begin
          state_nxt = S_SWP_CHK;
        end else if (sts.last_ring) begin
          state_nxt = S_CNT_FIN;
        end else begin
          cmd       = CMD_NEXT_RING;
          state_nxt = S_SWP_CHK;
        end
      end
      S_WIN_TOT: begin
        cmd       = CMD_WIN_TOT;
        state_nxt = S_WIN_RING;
      end
      S_WIN_RING: begin
        cmd = CMD_WIN_RING;
        if (sts.last_ring) begin
          state_nxt = S_CNT_FIN;
        end
      end
      S_CNT_FIN: begin
        cmd       = CMD_CNT_FIN;
        state_nxt = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (sts.res_free) begin
          cmd       = CMD_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// File: rtl/tcwsq_dp.sv
// Datapath: rings, pointers, configuration and result register
`timescale 1ns / 1ps
module tcwsq_dp #(
  parameter int HIGH_DEPTH   = 128,
  parameter int NORMAL_DEPTH = 512,
  parameter int LOW_DEPTH    = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcwsq_pkg::dp_cmd_t                    cmd,
  output tcwsq_pkg::dp_sts_t                    sts,
  input  logic [tcwsq_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [tcwsq_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                  cfg_we,
  input  logic [tcwsq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tcwsq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tcwsq_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [tcwsq_pkg::OUT_USER_W-1:0]      out_tuser
);
  import tcwsq_pkg::*;

  localparam int MAXD0 = (HIGH_DEPTH > NORMAL_DEPTH) ? HIGH_DEPTH : NORMAL_DEPTH;
  localparam int MAXD  = (MAXD0 > LOW_DEPTH) ? MAXD0 : LOW_DEPTH;
  localparam int DW    = $clog2(MAXD) + 1;
  localparam int MW    = (DW > WIN_W) ? DW : WIN_W;
  localparam int TW    = MW + 2;
  localparam int AWH   = $clog2(HIGH_DEPTH);
  localparam int AWN   = $clog2(NORMAL_DEPTH);
  localparam int AWL   = $clog2(LOW_DEPTH);

  typedef logic [DW-1:0] ptr_t;

  localparam ptr_t DEP [3] = '{ptr_t'(HIGH_DEPTH), ptr_t'(NORMAL_DEPTH), ptr_t'(LOW_DEPTH)};

  function automatic ptr_t step_p(ptr_t p, ptr_t d);
    ptr_t q;
    q = p + 1'b1;
    return (q == d) ? '0 : q;
  endfunction

  function automatic ptr_t span_p(ptr_t a, ptr_t b, ptr_t d);
    return (a >= b) ? ptr_t'(a - b) : ptr_t'(a + d - b);
  endfunction

  // Ring pointers
  ptr_t ret_r [3], ret_nxt [3];
  ptr_t snd_r [3], snd_nxt [3];
  ptr_t end_r [3], end_nxt [3];
  ptr_t wr_r  [3], wr_nxt  [3];

  // Configuration
  logic [WIN_W-1:0]  max_win_r;
  logic [WIN_W-1:0]  speed_r;
  logic [TIME_W-1:0] age_r;

  // Current item
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [1:0]        cls_r, cls_nxt;
  logic              bad_r, bad_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;

  // Scan state
  logic [1:0]        ring_r, ring_nxt;
  ptr_t              cur_r, cur_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;

  // Working result
  logic              ok_r, ok_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [ID_W-1:0]   sent_r, sent_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              any_r, any_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;

  // Output register
  logic                  ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;
  logic [OUT_USER_W-1:0] ou_r, ou_nxt;

  // RAM ports
  logic [ENTRY_W-1:0] rd_data [3];
  logic [ENTRY_W-1:0] cur_rd;
  logic [ENTRY_W-1:0] wr_entry;
  logic [2:0]         ram_we;

  // Combinational helpers
  logic              full;
  logic              found;
  logic [1:0]        found_ring;
  logic [TW-1:0]     total;
  logic [TW-1:0]     max_x;
  logic [WIN_W-1:0]  room;
  ptr_t              avail;
  logic [MW-1:0]     take;
  logic [DW:0]       end_sum;
  logic [TIME_W-1:0] age_now;

  assign cur_rd   = rd_data[ring_r];
  assign wr_entry = {now_r, pid_r};
  assign full     = (step_p(wr_r[cls_r], DEP[cls_r]) == ret_r[cls_r]);
  assign age_now  = now_r - cur_rd[ENTRY_W-1:ID_W];

  // Pick the first class with an unsent windowed entry
  always_comb begin
    found      = 1'b1;
    found_ring = RING_HIGH;
    priority if (snd_r[0] != end_r[0]) begin
      found_ring = RING_HIGH;
    end else if (snd_r[1] != end_r[1]) begin
      found_ring = RING_NORMAL;
    end else if (snd_r[2] != end_r[2]) begin
      found_ring = RING_LOW;
    end else begin
      found = 1'b0;
    end
  end

  // Window totals and the share opened in the current ring
  always_comb begin
    total = TW'(span_p(end_r[0], ret_r[0], DEP[0])) +
            TW'(span_p(end_r[1], ret_r[1], DEP[1])) +
            TW'(span_p(end_r[2], ret_r[2], DEP[2]));
    max_x = TW'(max_win_r);
    room  = '0;
    if (total < max_x) begin
      room = WIN_W'(max_x - total);
      if (room > speed_r) begin
        room = speed_r;
      end
    end
    avail   = span_p(wr_r[ring_r], end_r[ring_r], DEP[ring_r]);
    take    = (MW'(rem_r) < MW'(avail)) ? MW'(rem_r) : MW'(avail);
    end_sum = {1'b0, end_r[ring_r]} + (DW+1)'(take);
    if (end_sum >= {1'b0, DEP[ring_r]}) begin
      end_sum = end_sum - {1'b0, DEP[ring_r]};
    end
  end

  // Status towards the controller
  always_comb begin
    sts.op         = op_r;
    sts.at_send    = (cur_r == snd_r[ring_r]);
    sts.last_ring  = (ring_r == RING_LOW);
    sts.send_found = found;
    sts.id_match   = (cur_rd[ID_W-1:0] == pid_r);
    sts.aged       = (age_now > age_r);
    sts.res_free   = !ov_r || out_tready;
  end

  // Command execution
  always_comb begin
    ret_nxt  = ret_r;
    snd_nxt  = snd_r;
    end_nxt  = end_r;
    wr_nxt   = wr_r;
    op_nxt   = op_r;
    cls_nxt  = cls_r;
    bad_nxt  = bad_r;
    pid_nxt  = pid_r;
    now_nxt  = now_r;
    ring_nxt = ring_r;
    cur_nxt  = cur_r;
    rem_nxt  = rem_r;
    ok_nxt   = ok_r;
    st_nxt   = st_r;
    sent_nxt = sent_r;
    cnt_nxt  = cnt_r;
    any_nxt  = any_r;
    free_nxt = free_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    ou_nxt   = ou_r;
    ram_we   = '0;
    unique case (cmd)
      CMD_NONE: begin
      end
      // Capture the item and clear the working result
      CMD_LOAD: begin
        op_nxt   = in_tuser[OP_W-1:0];
        pid_nxt  = in_tdata[ID_W-1:0];
        now_nxt  = in_tdata[IN_DATA_W-1:ID_W];
        bad_nxt  = 1'b0;
        unique case (in_tuser[IN_USER_W-1:OP_W])
          PRI_VHIGH, PRI_HIGH: cls_nxt = RING_HIGH;
          PRI_NORMAL:          cls_nxt = RING_NORMAL;
          PRI_LOW:             cls_nxt = RING_LOW;
          default: begin
            cls_nxt = RING_HIGH;
            bad_nxt = 1'b1;
          end
        endcase
        ok_nxt   = 1'b0;
        st_nxt   = ST_OK;
        sent_nxt = '0;
        cnt_nxt  = '0;
        any_nxt  = 1'b0;
        free_nxt = '0;
      end
      CMD_ENQ: begin
        if (bad_r) begin
          st_nxt = ST_BADPRI;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ram_we[cls_r] = 1'b1;
          wr_nxt[cls_r] = step_p(wr_r[cls_r], DEP[cls_r]);
          ok_nxt        = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (bad_r) begin
          st_nxt = ST_BADPRI;
        end else begin
          free_nxt = FREE_W'(DEP[cls_r] - span_p(end_r[cls_r], ret_r[cls_r], DEP[cls_r]));
          ok_nxt   = 1'b1;
        end
      end
      // Claim the send slot; its id comes from the registered RAM read at the new cursor and is taken by CMD_SEND_CAP
      CMD_SEND_SEL: begin
        if (found) begin
          ring_nxt            = found_ring;
          cur_nxt             = snd_r[found_ring];
          snd_nxt[found_ring] = step_p(snd_r[found_ring], DEP[found_ring]);
          ok_nxt              = 1'b1;
        end else begin
          st_nxt = ST_NONE;
        end
      end
      CMD_SEND_CAP: begin
        sent_nxt = cur_rd[ID_W-1:0];
      end
      CMD_SCAN_START: begin
        ring_nxt = RING_HIGH;
        cur_nxt  = ret_r[0];
        st_nxt   = ST_NONE;
      end
      CMD_NEXT_RING: begin
        ring_nxt = ring_r + 2'd1;
        cur_nxt  = ret_r[ring_r + 2'd1];
      end
      // Match retires only the head
      CMD_ACK_CMP: begin
        if (cur_rd[ID_W-1:0] == pid_r) begin
          ok_nxt = 1'b1;
          st_nxt = ST_OK;
          if (cur_r == ret_r[ring_r]) begin
            ret_nxt[ring_r] = step_p(cur_r, DEP[ring_r]);
          end
        end else begin
          cur_nxt = step_p(cur_r, DEP[ring_r]);
        end
      end
      CMD_SWP_CMP: begin
        if (age_now > age_r) begin
          ret_nxt[ring_r] = step_p(cur_r, DEP[ring_r]);
          cur_nxt         = step_p(cur_r, DEP[ring_r]);
          cnt_nxt         = cnt_r + 1'b1;
          any_nxt         = 1'b1;
        end
      end
      CMD_WIN_TOT: begin
        rem_nxt  = room;
        ring_nxt = RING_HIGH;
      end
      CMD_WIN_RING: begin
        end_nxt[ring_r] = end_sum[DW-1:0];
        rem_nxt         = rem_r - WIN_W'(take);
        cnt_nxt         = cnt_r + CNT_W'(take);
        if (take != '0) begin
          any_nxt = 1'b1;
        end
        if (ring_r != RING_LOW) begin
          ring_nxt = ring_r + 2'd1;
        end
      end
      CMD_CNT_FIN: begin
        ok_nxt = any_r;
        st_nxt = any_r ? ST_OK : ST_NONE;
      end
      // Load the output register
      CMD_PUSH: begin
        ov_nxt = 1'b1;
        od_nxt = OUT_DATA_W'({free_r, cnt_r, sent_r});
        ou_nxt = {st_r, ok_r};
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r     <= '{default: '0};
      snd_r     <= '{default: '0};
      end_r     <= '{default: '0};
      wr_r      <= '{default: '0};
      ov_r      <= 1'b0;
      max_win_r <= WIN_W'(16);
      speed_r   <= WIN_W'(16);
      age_r     <= TIME_W'(60);
    end else begin
      ret_r <= ret_nxt;
      snd_r <= snd_nxt;
      end_r <= end_nxt;
      wr_r  <= wr_nxt;
      ov_r  <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MAX_WIN:    max_win_r <= cfg_wdata[WIN_W-1:0];
          CFG_SEND_SPEED: speed_r   <= cfg_wdata[WIN_W-1:0];
          CFG_TIMEOUT:    age_r     <= cfg_wdata[TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cls_r  <= cls_nxt;
    bad_r  <= bad_nxt;
    pid_r  <= pid_nxt;
    now_r  <= now_nxt;
    ring_r <= ring_nxt;
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    ok_r   <= ok_nxt;
    st_r   <= st_nxt;
    sent_r <= sent_nxt;
    cnt_r  <= cnt_nxt;
    any_r  <= any_nxt;
    free_r <= free_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
  end

  // Ring storage: {stamp, id} per slot
  tcwsq_ram #(.WIDTH(ENTRY_W), .DEPTH(HIGH_DEPTH)) u_high_ram (
    .clk     (clk),
    .wr_en   (ram_we[0]),
    .wr_addr (wr_r[0][AWH-1:0]),
    .wr_data (wr_entry),
    .rd_addr (cur_r[AWH-1:0]),
    .rd_data (rd_data[0])
  );

  tcwsq_ram #(.WIDTH(ENTRY_W), .DEPTH(NORMAL_DEPTH)) u_normal_ram (
    .clk     (clk),
    .wr_en   (ram_we[1]),
    .wr_addr (wr_r[1][AWN-1:0]),
    .wr_data (wr_entry),
    .rd_addr (cur_r[AWN-1:0]),
    .rd_data (rd_data[1])
  );

  tcwsq_ram #(.WIDTH(ENTRY_W), .DEPTH(LOW_DEPTH)) u_low_ram (
    .clk     (clk),
    .wr_en   (ram_we[2]),
    .wr_addr (wr_r[2][AWL-1:0]),
    .wr_data (wr_entry),
    .rd_addr (cur_r[AWL-1:0]),
    .rd_data (rd_data[2])
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

// File: rtl/three_class_windowed_send_queue_top.sv
// Enqueue, query and unknown ops finish directly; send picks a slot, then reads its id;
// ack searches the sent entries ring by ring; sweep checks heads ring by ring up to each
// ring's send point; window update sums the windows, then opens each ring. One item at a
// time, set by the single scan cursor and RAM read. The next beat is taken while a result
// waits in the output register.
// Reset clears pointers, result valid and loads configuration defaults (16, 16, 60);
// ring RAMs are not cleared.
`timescale 1ns / 1ps
module three_class_windowed_send_queue_top #(
  parameter int HIGH_DEPTH   = 128,
  parameter int NORMAL_DEPTH = 512,
  parameter int LOW_DEPTH    = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tcwsq_pkg::IN_DATA_W-1:0]  in_tdata,   // packet_id, now_time
  input  logic [tcwsq_pkg::IN_USER_W-1:0]  in_tuser,   // opcode, priority_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcwsq_pkg::OUT_DATA_W-1:0] out_tdata,  // sent_id, count, free_space
  output logic [tcwsq_pkg::OUT_USER_W-1:0] out_tuser,  // ok, status
  input  logic                             cfg_we,
  input  logic [tcwsq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tcwsq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcwsq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcwsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcwsq_dp #(
    .HIGH_DEPTH   (HIGH_DEPTH),
    .NORMAL_DEPTH (NORMAL_DEPTH),
    .LOW_DEPTH    (LOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/three_class_windowed_send_queue_top_tb.sv
// Self-checking testbench for the three-class windowed send queue
`timescale 1ns / 1ps
module three_class_windowed_send_queue_top_tb;
  import tcwsq_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int RING_MAX    = 512;

  typedef struct {
    logic              ok;
    logic [1:0]        status;
    logic [ID_W-1:0]   sent_id;
    logic [CNT_W-1:0]  count;
    logic [FREE_W-1:0] free_space;
  } queue_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  three_class_windowed_send_queue_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the queue state and registers
  int unsigned     ring_depth [3] = '{128, 512, 512};
  logic [ID_W-1:0] shadow_ids [3][RING_MAX];
  logic [31:0]     shadow_stamps [3][RING_MAX];
  int unsigned     shadow_ptr [3][4];  // retire, send, window end, write
  int unsigned     sh_max_window, sh_send_speed;
  logic [31:0]     sh_timeout;

  queue_result_t   pending_results[$];
  logic [ID_W-1:0] sent_log[$];
  int unsigned     error_count, beats_sent, beats_checked, cycle_count;
  logic [31:0]     clock_secs;
  bit              long_stall;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned window_fill(input int r);
    return (shadow_ptr[r][2] + ring_depth[r] - shadow_ptr[r][0]) % ring_depth[r];
  endfunction

  function automatic int unsigned ring_next(input int r, input int unsigned p);
    return (p + 1) % ring_depth[r];
  endfunction

  // Work out the result of one beat and advance the shadow state
  function automatic queue_result_t predict_queue(input logic [OP_W-1:0] op,
      input logic [PRI_W-1:0] pri, input logic [ID_W-1:0] pid, input logic [31:0] now);
    queue_result_t res;
    int cls, c;
    int unsigned w, i, total, room, k, cnt;
    bit moved;
    res = '{ok: 1'b0, status: ST_OK, sent_id: '0, count: '0, free_space: '0};
    cls = (pri <= PRI_HIGH) ? 0 : (pri == PRI_NORMAL) ? 1 : (pri == PRI_LOW) ? 2 : -1;
    cnt = 0;
    case (op)
      OP_ENQ: begin
        if (cls < 0) res.status = ST_BADPRI;
        else begin
          w = shadow_ptr[cls][3];
          if (ring_next(cls, w) == shadow_ptr[cls][0]) res.status = ST_FULL;
          else begin
            shadow_ids[cls][w] = pid;
            shadow_stamps[cls][w] = now;
            shadow_ptr[cls][3] = ring_next(cls, w);
            res.ok = 1'b1;
          end
        end
      end
      OP_SEND: begin
        res.status = ST_NONE;
        for (c = 0; c < 3; c++) begin
          if (res.ok == 1'b0 && shadow_ptr[c][1] != shadow_ptr[c][2]) begin
            res.sent_id = shadow_ids[c][shadow_ptr[c][1]];
            shadow_ptr[c][1] = ring_next(c, shadow_ptr[c][1]);
            res.ok = 1'b1;
            res.status = ST_OK;
          end
        end
      end
      OP_ACK: begin
        res.status = ST_NONE;
        for (c = 0; c < 3 && !res.ok; c++) begin
          i = shadow_ptr[c][0];
          while (i != shadow_ptr[c][1] && !res.ok) begin
            if (shadow_ids[c][i] == pid) begin
              // only a match at the head retires
              if (i == shadow_ptr[c][0]) shadow_ptr[c][0] = ring_next(c, i);
              res.ok = 1'b1;
              res.status = ST_OK;
            end
            i = ring_next(c, i);
          end
        end
      end
      OP_SWEEP: begin
        for (c = 0; c < 3; c++) begin
          while (shadow_ptr[c][0] != shadow_ptr[c][1] &&
                 (now - shadow_stamps[c][shadow_ptr[c][0]]) > sh_timeout) begin
            shadow_ptr[c][0] = ring_next(c, shadow_ptr[c][0]);
            cnt++;
          end
        end
        if (cnt > 0) res.ok = 1'b1; else res.status = ST_NONE;
      end
      OP_WIN: begin
        total = window_fill(0) + window_fill(1) + window_fill(2);
        if (total < sh_max_window) begin
          room = sh_max_window - total;
          if (room > sh_send_speed) room = sh_send_speed;
          moved = 1'b1;
          for (k = 0; k < room && moved; k++) begin
            moved = 1'b0;
            for (c = 0; c < 3 && !moved; c++) begin
              if (shadow_ptr[c][2] != shadow_ptr[c][3]) begin
                shadow_ptr[c][2] = ring_next(c, shadow_ptr[c][2]);
                moved = 1'b1;
              end
            end
            if (moved) cnt++;
          end
        end
        if (cnt > 0) res.ok = 1'b1; else res.status = ST_NONE;
      end
      OP_QUERY: begin
        if (cls < 0) res.status = ST_BADPRI;
        else begin
          res.free_space = FREE_W'(ring_depth[cls] - window_fill(cls));
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(cnt);
    return res;
  endfunction

  // Sender gap: mostly short, sometimes none, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Send one beat; called and returns at a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [PRI_W-1:0] pri,
      input logic [ID_W-1:0] pid, input logic [31:0] now, input bit no_gap = 1'b0);
    int unsigned gap;
    queue_result_t res;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, pid};
    in_tuser  <= {pri, op};
    do @(posedge clk); while (!in_tready);
    res = predict_queue(op, pri, pid, now);
    pending_results.push_back(res);
    if (op == OP_SEND && res.ok) begin
      sent_log.push_back(res.sent_id);
      if (sent_log.size() > 64) void'(sent_log.pop_front());
    end
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is back, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_MAX_WIN:    sh_max_window = val[WIN_W-1:0];
      CFG_SEND_SPEED: sh_send_speed = val[WIN_W-1:0];
      CFG_TIMEOUT:    sh_timeout    = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] win, input logic [31:0] speed,
      input logic [31:0] age);
    wait_drained();
    write_reg(CFG_MAX_WIN, win);
    write_reg(CFG_SEND_SPEED, speed);
    write_reg(CFG_TIMEOUT, age);
  endtask

  // Result checker
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (pending_results.size() == 0) report("result beat with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.ok)
          report($sformatf("ok %b, expected %b", out_tuser[0], want.ok));
        if (out_tuser[2:1] !== want.status)
          report($sformatf("status %0d, expected %0d", out_tuser[2:1], want.status));
        if (out_tdata[31:0] !== want.sent_id)
          report($sformatf("sent_id %h, expected %h", out_tdata[31:0], want.sent_id));
        if (out_tdata[42:32] !== want.count)
          report($sformatf("count %0d, expected %0d", out_tdata[42:32], want.count));
        if (out_tdata[52:43] !== want.free_space)
          report($sformatf("free_space %0d, expected %0d", out_tdata[52:43],
                           want.free_space));
      end
    end
  end

  // Receiver stalls: short random ones, with occasional long stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) long_stall = !long_stall;
    if (long_stall) out_tready <= ($urandom_range(0, 19) == 0);
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  // Edge cases first: bad classes, empty rings, unknown opcodes, head and non-head acks
  task automatic test_directed();
    int p;
    for (p = 0; p <= 4; p++) send_item(OP_QUERY, PRI_W'(p), '0, '0);
    send_item(OP_SEND, PRI_VHIGH, '0, '0);
    send_item(OP_ACK, PRI_VHIGH, 32'hFFFF_FFFF, '0);
    send_item(OP_SWEEP, PRI_VHIGH, '0, 32'hFFFF_FFFF);
    send_item(OP_WIN, PRI_VHIGH, '0, '0);
    send_item(3'd6, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 3'd5, 32'h0, 32'h0);
    send_item(OP_ENQ, 3'd6, 32'h1234, 32'd5);
    send_item(OP_ENQ, PRI_LOW, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(OP_ENQ, PRI_NORMAL, 32'h0, 32'hFFFF_FFF0);
    send_item(OP_ENQ, PRI_HIGH, 32'hA5A5_A5A5, 32'hFFFF_FFF0);
    send_item(OP_ENQ, PRI_VHIGH, 32'h5A5A_5A5A, 32'hFFFF_FFF0);
    send_item(OP_WIN, PRI_VHIGH, '0, '0);
    send_item(OP_QUERY, PRI_HIGH, '0, '0);
    for (p = 0; p < 4; p++) send_item(OP_SEND, PRI_VHIGH, '0, '0);
    send_item(OP_ACK, PRI_VHIGH, 32'h5A5A_5A5A, '0);   // not at the head: found, not retired
    send_item(OP_ACK, PRI_VHIGH, 32'hA5A5_A5A5, '0);   // head: retire
    send_item(OP_SWEEP, PRI_VHIGH, '0, 32'd20);        // age wraps past zero
    send_item(OP_SWEEP, PRI_VHIGH, '0, 32'd40);
  endtask

  // Fill the high and low rings to the drop point, open the window, retire a few heads
  task automatic test_ring_full();
    int n;
    set_regs(32'd1023, 32'd1023, 32'd0);
    for (n = 0; n < 128; n++) send_item(OP_ENQ, PRI_HIGH, $urandom(), 32'd100, 1'b1);
    for (n = 0; n < 512; n++) send_item(OP_ENQ, PRI_LOW, $urandom(), 32'd100, 1'b1);
    send_item(OP_QUERY, PRI_LOW, '0, '0);
    send_item(OP_WIN, PRI_VHIGH, '0, '0);
    send_item(OP_QUERY, PRI_VHIGH, '0, '0);
    send_item(OP_QUERY, PRI_LOW, '0, '0);
    for (n = 0; n < 16; n++) send_item(OP_SEND, PRI_VHIGH, '0, '0, 1'b1);
    send_item(OP_SWEEP, PRI_VHIGH, '0, 32'd101);
  endtask

  // Mostly well-formed traffic: enqueue, open, send, ack sent ids, sweep
  task automatic test_random(input int unsigned items);
    int unsigned n, roll;
    logic [OP_W-1:0]  op;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  pid;
    logic [31:0]      now;
    for (n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 33) op = OP_ENQ;
      else if (roll < 48) op = OP_WIN;
      else if (roll < 68) op = OP_SEND;
      else if (roll < 85) op = OP_ACK;
      else if (roll < 93) op = OP_SWEEP;
      else if (roll < 98) op = OP_QUERY;
      else op = OP_W'($urandom_range(6, 7));
      pri = ($urandom_range(0, 19) == 0) ? PRI_W'($urandom_range(4, 7))
                                         : PRI_W'($urandom_range(0, 3));
      pid = $urandom();
      if (op == OP_ACK && sent_log.size() != 0 && $urandom_range(0, 9) < 8)
        pid = sent_log[$urandom_range(0, sent_log.size() - 1)];
      clock_secs += $urandom_range(0, 3);
      now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_secs;
      send_item(op, pri, pid, now);
      // sender holds off now and then until the queue is quiet
      if (n % 50 == 49) wait_drained();
    end
  endtask

  task automatic test_register_sweep();
    set_regs(32'd1, 32'd1, 32'd0);
    test_random(75);
    set_regs(32'd1023, 32'd1023, 32'hFFFF_FFFF);
    test_random(75);
    set_regs(32'd8, 32'd3, 32'd5);
    test_random(75);
    set_regs($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 20));
    test_random(75);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cycle_count = 0;
    error_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    clock_secs = 32'd1000;
    long_stall = 1'b0;
    foreach (shadow_ptr[r, p]) shadow_ptr[r][p] = 0;
    foreach (shadow_ids[r, i]) begin
      shadow_ids[r][i] = '0;
      shadow_stamps[r][i] = '0;
    end
    sh_max_window = 16;
    sh_send_speed = 16;
    sh_timeout = 32'd60;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(100);
    test_register_sweep();
    test_ring_full();

    // drain and let the block settle
    wait_drained();
    repeat (50) @(negedge clk);
    $display("Covered %0d beats sent and %0d results checked over directed, ring-full",
             beats_sent, beats_checked);
    $display("and random traffic at several window, speed and timeout settings");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: three_class_windowed_send_queue_top.f
rtl/tcwsq_pkg.sv
rtl/tcwsq_ram.sv
rtl/tcwsq_ctrl.sv
rtl/tcwsq_dp.sv
rtl/three_class_windowed_send_queue_top.sv
tb/three_class_windowed_send_queue_top_tb.sv
